// ----- rtl/qklms_pkg.sv -----
`default_nettype none
package qklms_pkg;

	localparam int MAX_CENTERS = 256;
	localparam int EXP_DEPTH   = 256;
	localparam int ADDR_W      = $clog2(MAX_CENTERS);
	localparam int CNT_W       = $clog2(MAX_CENTERS + 1);
	localparam int EXP_AW      = $clog2(EXP_DEPTH);
	localparam int KERN_W      = 17;
	localparam int PROD_W      = 32 + KERN_W;

	// register indexes on the config port
	localparam logic [1:0] REG_STEP  = 2'd0;
	localparam logic [1:0] REG_SCALE = 2'd1;
	localparam logic [1:0] REG_THR   = 2'd2;

	typedef logic [KERN_W-1:0] exp_tab_t [EXP_DEPTH];

	// exp(-8 i / depth) in Q1.16, built from a Taylor-series step factor
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    t;
		logic [63:0] h;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] acc;
		h    = (64'd8 << 32) / 64'(EXP_DEPTH);
		term = 64'd1 << 32;
		r    = term;
		acc  = 64'd1 << 32;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * h) >> 32) / 64'(k);
			if (k % 2 == 1) r = r - term;
			else r = r + term;
		end
		for (int i = 0; i < EXP_DEPTH; i++) begin
			t[i] = KERN_W'((acc + 64'd32768) >> 16);
			acc  = (acc * r) >> 32;
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// kernel unit results back to the sequencer
	typedef struct packed {
		logic                     dist_valid;
		logic [23:0]              dist_abs;
		logic [ADDR_W-1:0]        dist_idx;
		logic                     prod_valid;
		logic signed [PROD_W-1:0] prod;
		logic                     busy;
	} kern_res_t;

endpackage
`default_nettype wire

// ----- rtl/qklms_kern.sv -----
`default_nettype none
module qklms_kern (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	input  wire [qklms_pkg::ADDR_W-1:0]      in_idx,
	input  wire signed [23:0]                sample,
	input  wire signed [23:0]                center,
	input  wire signed [31:0]                weight,
	input  wire [23:0]                       scale,
	output qklms_pkg::kern_res_t             res
);
	import qklms_pkg::*;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [23:0]              ad_s1;
	logic [ADDR_W-1:0]        idx_s1;
	logic signed [31:0]       w_s1, w_s2, w_s3, w_s4;
	logic [31:0]              sq_s2;
	logic [39:0]              x_s3;
	logic [KERN_W-1:0]        k_s4;
	logic signed [PROD_W-1:0] p_s5;

	logic signed [24:0] diff;
	logic [47:0]        sq_full;
	logic [55:0]        x_full;
	logic [31:0]        idx_full;

	assign diff     = 25'(sample) - 25'(center);
	assign sq_full  = 48'(ad_s1) * 48'(ad_s1);
	assign x_full   = 56'(sq_s2) * 56'(scale);
	assign idx_full = 32'(x_s3[18:0]) * 32'(EXP_DEPTH);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// distance, square, scale, table, weight product
	always_ff @(posedge clk) begin
		ad_s1  <= diff[24] ? 24'(-diff) : diff[23:0];
		idx_s1 <= in_idx;
		w_s1   <= weight;
		sq_s2  <= sq_full[47:16];
		w_s2   <= w_s1;
		x_s3   <= x_full[55:16];
		w_s3   <= w_s2;
		k_s4   <= (x_s3 >= (40'd8 << 16)) ? '0 : EXP_TAB[idx_full[19 +: EXP_AW]];
		w_s4   <= w_s3;
		p_s5   <= PROD_W'(w_s4) * $signed({1'b0, k_s4});
	end

	assign res.dist_valid = v_s1;
	assign res.dist_abs   = ad_s1;
	assign res.dist_idx   = idx_s1;
	assign res.prod_valid = v_s5;
	assign res.prod       = p_s5;
	assign res.busy       = in_valid | v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

endmodule
`default_nettype wire

// ----- rtl/qklms_kernel_predictor.sv -----
// Sequence, from the accepting cycle: a seed item runs MUL then WB; any other item
// scans the N centers held (at most 256), drains the kernel pipeline, then runs ERR, MUL and WB.
// Throughput: one item at a time; the scan issues one center per cycle into
// the kernel pipeline, whose single memory read port sets the length.
// Reset clears the sequencer, the center count and the config registers to their
// defaults; center and weight memories are not cleared.
`default_nettype none
module qklms_kernel_predictor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // sample[23:0], desired[47:24]
	input  wire         s_tuser,   // start_of_sequence
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [79:0] m_tdata,   // prediction, pred_error, center_count,
	                               // center_added, codebook_full, zero pad
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [23:0] cfg_data
);
	import qklms_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_ERR   = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_WB    = 6'b100000
	} state_t;

	state_t state_q;

	logic [15:0] step_q;
	logic [23:0] scale_q;
	logic [22:0] thr_q;

	logic signed [23:0] u_q, d_q;
	logic               seed_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  j_q;
	logic signed [63:0] acc_q;
	logic [23:0]        best_q;
	logic [ADDR_W-1:0]  bi_q;
	logic signed [31:0] y_q, e_q;
	logic signed [49:0] prod_q;

	// memories
	logic signed [23:0] cen_mem [MAX_CENTERS];
	logic signed [31:0] w_mem   [MAX_CENTERS];
	logic [ADDR_W-1:0]  rd_addr;
	logic signed [23:0] cen_rd_q;
	logic signed [31:0] w_rd_q;
	logic               issue, issue_q;
	logic [ADDR_W-1:0]  issue_idx_q;
	logic               we;
	logic [ADDR_W-1:0]  wa;
	logic signed [23:0] wc;
	logic signed [31:0] ww;
	logic               wc_en;

	kern_res_t kres;

	logic               s_acc, out_free;
	logic signed [33:0] upd;
	logic signed [31:0] w_new_seed, w_new_upd, w_new_add;
	logic               near;
	logic               cnt_full;

	assign s_acc    = s_tvalid & s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;
	assign issue    = (state_q == ST_SCAN);
	assign upd      = prod_q[49:16];
	assign near     = (best_q <= {1'b0, thr_q});
	assign cnt_full = (cnt_q == CNT_W'(MAX_CENTERS));

	assign w_new_seed = sat32(64'(upd));
	assign w_new_add  = w_new_seed;
	assign w_new_upd  = sat32(64'(w_rd_q) + 64'(upd));

	always_comb begin
		rd_addr = (state_q == ST_SCAN) ? j_q : bi_q;
	end

	// write port selection
	always_comb begin
		we    = 1'b0;
		wc_en = 1'b0;
		wa    = bi_q;
		wc    = u_q;
		ww    = w_new_upd;
		if (state_q == ST_WB && out_free) begin
			we = 1'b1;
			if (seed_q) begin
				wc_en = 1'b1;
				wa    = '0;
				ww    = w_new_seed;
			end else if (!near && !cnt_full) begin
				wc_en = 1'b1;
				wa    = cnt_q[ADDR_W-1:0];
				ww    = w_new_add;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) w_mem[wa] <= ww;
		if (we && wc_en) cen_mem[wa] <= wc;
		cen_rd_q    <= cen_mem[rd_addr];
		w_rd_q      <= w_mem[rd_addr];
		issue_idx_q <= j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) issue_q <= 1'b0;
		else issue_q <= issue;
	end

	qklms_kern u_kern (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (issue_q),
		.in_idx   (issue_idx_q),
		.sample   (u_q),
		.center   (cen_rd_q),
		.weight   (w_rd_q),
		.scale    (scale_q),
		.res      (kres)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 16'd6554;
			scale_q <= 24'd32768;
			thr_q   <= 23'd13107;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP:  step_q  <= cfg_data[15:0];
				REG_SCALE: scale_q <= cfg_data;
				REG_THR:   thr_q   <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_WB && out_free) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_acc) begin
					if (s_tuser || cnt_q == '0) state_q <= ST_MUL;
					else state_q <= ST_SCAN;
				end
				ST_SCAN:  if (CNT_W'(j_q) == cnt_q - 1'b1) state_q <= ST_DRAIN;
				ST_DRAIN: if (!kres.busy) state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_WB;
				ST_WB: if (out_free) begin
					state_q  <= ST_IDLE;
					if (seed_q) cnt_q <= CNT_W'(1);
					else if (!near && !cnt_full) cnt_q <= cnt_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			u_q    <= s_tdata[23:0];
			d_q    <= s_tdata[47:24];
			seed_q <= s_tuser || cnt_q == '0;
			j_q    <= '0;
			acc_q  <= '0;
		end
		if (state_q == ST_SCAN) j_q <= j_q + 1'b1;
		// nearest search, lowest index wins ties
		if (kres.dist_valid && (kres.dist_idx == '0 || kres.dist_abs < best_q)) begin
			best_q <= kres.dist_abs;
			bi_q   <= kres.dist_idx;
		end
		if (kres.prod_valid) acc_q <= acc_q + 64'(kres.prod);
		if (state_q == ST_ERR) begin
			y_q <= sat32(acc_q >>> 16);
			e_q <= sat32(64'(d_q) - 64'(sat32(acc_q >>> 16)));
		end
		if (state_q == ST_MUL) begin
			prod_q <= $signed({1'b0, step_q}) * 50'(seed_q ? 32'(d_q) : e_q);
		end
		if (state_q == ST_WB && out_free) begin
			if (seed_q) begin
				m_tdata[31:0]  <= w_new_seed;
				m_tdata[63:32] <= sat32(64'(d_q) - 64'(w_new_seed));
				m_tdata[72:64] <= CNT_W'(1);
				m_tdata[73]    <= 1'b1;
				m_tdata[74]    <= 1'b0;
			end else begin
				m_tdata[31:0]  <= y_q;
				m_tdata[63:32] <= e_q;
				m_tdata[72:64] <= (!near && !cnt_full) ? cnt_q + 1'b1 : cnt_q;
				m_tdata[73]    <= !near && !cnt_full;
				m_tdata[74]    <= !near && cnt_full;
			end
			m_tdata[79:75] <= '0;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CENTERS))
		else $error("center count above capacity");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !kres.prod_valid)
		else $error("kernel pipeline active while idle");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[73] && m_tdata[74]))
		else $error("added and full both set");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERR) |-> $past(state_q == ST_DRAIN) && !kres.busy)
		else $error("error step before pipeline drained");
`endif

endmodule
`default_nettype wire
